FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  `ASSERT_AT(lbl, clk, rst, !(cond), msg)

`endif

FILE: rtl/core/lrast_pkg.sv
// -----------------------------------------------------------------------------
// lrast_pkg
// Shared types and constants of the line rasterizer.
// -----------------------------------------------------------------------------
`default_nettype none

package lrast_pkg;

  // Default geometry and queue sizing
  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Fixed field widths on the stream ports
  localparam int PIX_W      = 12;
  localparam int COLOR_W    = 16;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  // Input tdata layout
  localparam int START_X_LSB = 0;
  localparam int START_Y_LSB = 12;
  localparam int END_X_LSB   = 24;
  localparam int END_Y_LSB   = 36;
  localparam int PEN_LSB     = 48;

  // Item kind carried on tuser
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_t;

  // Per-entry control flags carried through the command queue
  typedef struct packed {
    kind_t kind;
    logic  steep;
    logic  minor_down;
  } cmd_ctrl_t;

  localparam int CTRL_W = $bits(cmd_ctrl_t);

endpackage

`default_nettype wire

FILE: rtl/core/lrast_front.sv
// -----------------------------------------------------------------------------
// lrast_front
// Accepts input beats, classifies start and step items, and does line setup.
// -----------------------------------------------------------------------------
`default_nettype none

module lrast_front #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], pen_color[63:48]
  input  wire logic [lrast_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // kind
  input  wire logic                           s_axis_tuser,
  input  wire logic                           q_full,
  output logic                                q_push,
  output lrast_pkg::cmd_ctrl_t                q_ctrl,
  // maj0, min0, maj1, delta_major, delta_minor from the lowest field up
  output logic [5*COORD_BITS-1:0]             q_geom,
  output logic [lrast_pkg::COLOR_W-1:0]       q_color
);

  import lrast_pkg::*;

  logic [COORD_BITS-1:0] ax, ay, bx, by;
  logic                  gx, gy, steep, g_maj, g_min, down;
  logic [COORD_BITS-1:0] sx, sy;
  logic [COORD_BITS-1:0] maj_a, maj_b, min_a, min_b, d_maj, d_min;
  logic [COORD_BITS-1:0] maj0, maj1, min0;

  // Narrow the endpoints to the coordinate width
  assign ax = COORD_BITS'(s_axis_tdata[START_X_LSB +: PIX_W]);
  assign ay = COORD_BITS'(s_axis_tdata[START_Y_LSB +: PIX_W]);
  assign bx = COORD_BITS'(s_axis_tdata[END_X_LSB +: PIX_W]);
  assign by = COORD_BITS'(s_axis_tdata[END_Y_LSB +: PIX_W]);

  // Spans along each axis
  always_comb begin
    gx = ax > bx;
    gy = ay > by;
    sx = gx ? (ax - bx) : (bx - ax);
    sy = gy ? (ay - by) : (by - ay);
    steep = sy > sx;
  end

  // Pick major and minor axis, then order along the major axis
  always_comb begin
    maj_a = steep ? ay : ax;
    maj_b = steep ? by : bx;
    min_a = steep ? ax : ay;
    min_b = steep ? bx : by;
    g_maj = steep ? gy : gx;
    g_min = steep ? gx : gy;
    d_maj = steep ? sy : sx;
    d_min = steep ? sx : sy;
    maj0  = g_maj ? maj_b : maj_a;
    maj1  = g_maj ? maj_a : maj_b;
    min0  = g_maj ? min_b : min_a;
    // minor coordinate walks down unless the ordered start lies below the end
    down  = g_maj ? !g_min : (g_min || (d_min == '0));
  end

  // Push every accepted beat into the command queue
  assign s_axis_tready    = !q_full;
  assign q_push           = s_axis_tvalid && !q_full;
  assign q_ctrl.kind      = kind_t'(s_axis_tuser);
  assign q_ctrl.steep     = steep;
  assign q_ctrl.minor_down = down;
  assign q_geom           = {d_min, d_maj, maj1, min0, maj0};
  assign q_color          = s_axis_tdata[PEN_LSB +: COLOR_W];

endmodule

`default_nettype wire

FILE: rtl/core/lrast_queue.sv
// -----------------------------------------------------------------------------
// lrast_queue
// Short command queue between the setup front and the stepping back end.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lrast_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lrast_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  not_empty,
  output logic                  full
);

  import lrast_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rdata     = entries[rd_ptr];
  assign not_empty = (count != '0);
  assign full      = (count == CNT_W'(DEPTH));

  `ASSERT_AT(a_count_in_range, clk, rst, count <= CNT_W'(DEPTH), "queue overfilled")
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && (count == '0), "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/core/lrast_back.sv
// -----------------------------------------------------------------------------
// lrast_back
// Holds the active line and steps it one pixel per step command.
// -----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module lrast_back #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            q_valid,
  input  wire lrast_pkg::cmd_ctrl_t            q_ctrl,
  input  wire logic [5*COORD_BITS-1:0]         q_geom,
  input  wire logic [lrast_pkg::COLOR_W-1:0]   q_color,
  output logic                                 q_pop,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], pixel_color[39:24]
  output logic [lrast_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);

  import lrast_pkg::*;

  localparam int CB = COORD_BITS;

  logic [CB-1:0]        major_pos, minor_pos, major_end, delta_major, delta_minor;
  logic signed [CB:0]   error_term;
  logic                 is_steep, minor_down, line_active;
  logic [COLOR_W-1:0]   line_color;

  logic [CB-1:0]        g_maj0, g_min0, g_maj1, g_dmaj, g_dmin;
  logic                 advance, emit, is_last;
  logic signed [CB:0]   err_sub, err_add;
  logic [CB-1:0]        px, py;

  assign {g_dmin, g_dmaj, g_maj1, g_min0, g_maj0} = q_geom;

  // Take a command whenever the output register is free or draining
  assign advance = !m_axis_tvalid || m_axis_tready;
  assign q_pop   = q_valid && advance;
  assign emit    = q_pop && (q_ctrl.kind == KIND_STEP) && line_active;
  assign is_last = (major_pos == major_end);

  // Error update for the next pixel
  assign err_sub = error_term - $signed({1'b0, delta_minor});
  assign err_add = err_sub + $signed({1'b0, delta_major});

  // Swap back to x and y
  assign px = is_steep ? minor_pos : major_pos;
  assign py = is_steep ? major_pos : minor_pos;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active   <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        m_axis_tvalid <= emit;
      end
      if (q_pop && (q_ctrl.kind == KIND_START)) begin
        line_active <= 1'b1;
      end else if (emit && is_last) begin
        line_active <= 1'b0;
      end
    end
  end

  // Line state: load on start, walk on step
  always_ff @(posedge clk) begin
    if (q_pop && (q_ctrl.kind == KIND_START)) begin
      major_pos   <= g_maj0;
      minor_pos   <= g_min0;
      major_end   <= g_maj1;
      delta_major <= g_dmaj;
      delta_minor <= g_dmin;
      error_term  <= $signed({2'b00, g_dmaj[CB-1:1]});
      is_steep    <= q_ctrl.steep;
      minor_down  <= q_ctrl.minor_down;
      line_color  <= q_color;
    end else if (emit && !is_last) begin
      major_pos <= major_pos + 1'b1;
      if (err_sub < 0) begin
        minor_pos  <= minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
        error_term <= err_add;
      end else begin
        error_term <= err_sub;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= {line_color, PIX_W'(py), PIX_W'(px)};
      m_axis_tlast <= is_last;
    end
  end

  `ASSERT_AT(a_err_nonneg, clk, rst, line_active |-> !error_term[CB],
             "error term negative on an active line")
  `ASSERT_AT(a_beat_from_line, clk, rst, $rose(m_axis_tvalid) |-> $past(line_active),
             "pixel beat without an active line")

endmodule

`default_nettype wire

FILE: rtl/core/line_rasterizer_unit.sv
// -----------------------------------------------------------------------------
// line_rasterizer_unit
// Bresenham line stepper: start beats load a line, step beats emit pixels.
// -----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis_*: tuser selects the beat kind (start or step). A start
//   beat carries both endpoints and the pen color and emits nothing; a line in
//   progress is dropped. A step beat emits the next pixel of the active line,
//   or nothing when no line is active.
//   Output stream m_axis_*: one beat per pixel, tlast set on the final pixel.
//   Throughput: one input beat per clock, one pixel per clock sustained while m_axis_tready stays high.
//   A step beat is written into the queue when it is accepted and shows its
//   pixel on m_axis from the stepper output register.
//   The setup front and the stepper are parted by a command queue of
//   QUEUE_DEPTH entries; when m_axis_tready is low the stepper holds its
//   pixel, the queue fills, and s_axis_tready drops once it is full.
//   Reset (rst, synchronous) empties the queue, clears the output valid and
//   leaves no active line.
// -----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_unit #(
  parameter int COORD_BITS  = lrast_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = lrast_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // start_x[11:0], start_y[23:12], end_x[35:24], end_y[47:36], pen_color[63:48]
  input  wire logic [lrast_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // pixel_x[11:0], pixel_y[23:12], pixel_color[39:24]
  output logic [lrast_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);

  import lrast_pkg::*;

  localparam int GEOM_W  = 5 * COORD_BITS;
  localparam int ENTRY_W = CTRL_W + COLOR_W + GEOM_W;

  logic                q_full, q_push, q_pop, q_not_empty;
  cmd_ctrl_t           wr_ctrl, rd_ctrl;
  logic [GEOM_W-1:0]   wr_geom, rd_geom;
  logic [COLOR_W-1:0]  wr_color, rd_color;
  logic [ENTRY_W-1:0]  wr_entry, rd_entry;

  lrast_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_ctrl       (wr_ctrl),
    .q_geom       (wr_geom),
    .q_color      (wr_color)
  );

  assign wr_entry = {wr_ctrl, wr_color, wr_geom};

  lrast_queue #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (wr_entry),
    .pop      (q_pop),
    .rdata    (rd_entry),
    .not_empty(q_not_empty),
    .full     (q_full)
  );

  assign {rd_ctrl, rd_color, rd_geom} = rd_entry;

  lrast_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_not_empty),
    .q_ctrl       (rd_ctrl),
    .q_geom       (rd_geom),
    .q_color      (rd_color),
    .q_pop        (q_pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: sim/line_rasterizer_unit_tb.sv
// -----------------------------------------------------------------------------
// line_rasterizer_unit_tb
// Self-checking bench for the Bresenham line stepper.
// -----------------------------------------------------------------------------
// A table of directed beats covers these cases:
//   - steps while no line is active
//   - single point lines at both corners of the coordinate range
//   - a diagonal with equal spans
//   - steep and reversed lines
//   - a line abandoned by a new start
//   - step beats whose unused fields are all ones
// Random line sequences follow, with some noise beats mixed in. Most lines are
// short, and a few span the whole coordinate range. Every beat accepted on the
// input updates a line predictor kept in the bench, and every pixel leaving
// the block is compared with the oldest predicted pixel. Idle gaps on both
// sides change by phase. One long stall on the output fills the command queue
// and pushes back on the input.
// -----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer_unit_tb;
  import lrast_pkg::*;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_BEATS = 1525;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int NUM_DIRECTED = 25;

  // How a beat's outcome is checked
  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_NONE,
    CHK_PIXEL
  } row_check_t;

  typedef struct packed {
    logic               last;
    logic [COLOR_W-1:0] color;
    logic [PIX_W-1:0]   y;
    logic [PIX_W-1:0]   x;
  } pixel_t;

  typedef struct {
    kind_t              kind;
    logic [PIX_W-1:0]   sx;
    logic [PIX_W-1:0]   sy;
    logic [PIX_W-1:0]   ex;
    logic [PIX_W-1:0]   ey;
    logic [COLOR_W-1:0] pen;
    row_check_t         chk;
    pixel_t             want;
  } line_row_t;

  typedef struct {
    row_check_t chk;
    pixel_t     want;
  } beat_note_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic                 s_axis_tuser = KIND_START;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;

  // Bench-side copy of the line state
  logic [PIX_W-1:0]   ln_major, ln_minor, ln_major_end;
  logic [PIX_W-1:0]   ln_span_major, ln_span_minor;
  int                 ln_err;
  logic               ln_steep, ln_down, ln_active;
  logic [COLOR_W-1:0] ln_color;

  pixel_t     pixel_expect_q[$];
  beat_note_t beat_note_q[$];

  int fail_count = 0;
  int beats_in = 0;
  int pixels_checked = 0;
  int lines_started = 0;
  int lines_finished = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 77;
  int hold_left = 0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;

  line_row_t line_plan [NUM_DIRECTED] = '{
    // step with no line loaded after reset
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_NONE,  '0},
    // single point at the origin
    '{KIND_START, 12'h000, 12'h000, 12'h000, 12'h000, 16'hFFFF, CHK_NONE,  '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_PIXEL,
      '{1'b1, 16'hFFFF, 12'h000, 12'h000}},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_NONE,  '0},
    // single point at the far corner, step fields all ones and ignored
    '{KIND_START, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'h0000, CHK_NONE,  '0},
    '{KIND_STEP,  12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 16'hFFFF, CHK_PIXEL,
      '{1'b1, 16'h0000, 12'hFFF, 12'hFFF}},
    // full-range diagonal, equal spans walk along x
    '{KIND_START, 12'hFFF, 12'h000, 12'h000, 12'hFFF, 16'hA5A5, CHK_NONE,  '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_PIXEL,
      '{1'b0, 16'hA5A5, 12'hFFF, 12'h000}},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    // steep line given end first, abandons the diagonal
    '{KIND_START, 12'h00A, 12'h014, 12'h008, 12'h00A, 16'h5A5A, CHK_NONE,  '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    // short steep line run to its end
    '{KIND_START, 12'h000, 12'h000, 12'h001, 12'h002, 16'h0F0F, CHK_NONE,  '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_NONE,  '0},
    // full-width horizontal line given right to left
    '{KIND_START, 12'hFFF, 12'h000, 12'h000, 12'h000, 16'h07E0, CHK_NONE,  '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_PIXEL,
      '{1'b0, 16'h07E0, 12'h000, 12'h000}},
    // descending diagonal run to its end
    '{KIND_START, 12'h005, 12'h007, 12'h009, 12'h003, 16'hF800, CHK_NONE,  '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0},
    '{KIND_STEP,  12'h000, 12'h000, 12'h000, 12'h000, 16'h0000, CHK_MODEL, '0}
  };

  line_rasterizer_unit dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always #(HALF_PERIOD) clk = ~clk;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic logic [IN_DATA_W-1:0] pack_line(input logic [PIX_W-1:0] sx,
                                                     input logic [PIX_W-1:0] sy,
                                                     input logic [PIX_W-1:0] ex,
                                                     input logic [PIX_W-1:0] ey,
                                                     input logic [COLOR_W-1:0] pen);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[START_X_LSB +: PIX_W] = sx;
    d[START_Y_LSB +: PIX_W] = sy;
    d[END_X_LSB +: PIX_W]   = ex;
    d[END_Y_LSB +: PIX_W]   = ey;
    d[PEN_LSB +: COLOR_W]   = pen;
    return d;
  endfunction

  // Clamp base plus a random offset of up to reach into the coordinate range
  function automatic logic [PIX_W-1:0] near_coord(input int base, input int reach);
    int v;
    v = base + int'($urandom_range(2 * reach)) - reach;
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return v[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] rail_coord();
    return ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
  endfunction

  // Load a line on start, or emit the next pixel and advance the walk on step
  function automatic void bresenham_advance(input kind_t k,
                                            input logic [IN_DATA_W-1:0] d,
                                            output logic emits,
                                            output pixel_t px);
    logic [PIX_W-1:0] ax, ay, bx, by, maj0, min0, maj1, min1;
    logic at_end;
    emits = 1'b0;
    px    = '0;
    if (k == KIND_START) begin
      ax = d[START_X_LSB +: PIX_W];
      ay = d[START_Y_LSB +: PIX_W];
      bx = d[END_X_LSB +: PIX_W];
      by = d[END_Y_LSB +: PIX_W];
      ln_steep = abs_diff(ay, by) > abs_diff(ax, bx);
      if (ln_steep) {maj0, min0, maj1, min1} = {ay, ax, by, bx};
      else {maj0, min0, maj1, min1} = {ax, ay, bx, by};
      // order so the major coordinate rises
      if (maj0 > maj1) begin
        {maj0, maj1} = {maj1, maj0};
        {min0, min1} = {min1, min0};
      end
      ln_major      = maj0;
      ln_minor      = min0;
      ln_major_end  = maj1;
      ln_span_major = maj1 - maj0;
      ln_span_minor = abs_diff(min0, min1);
      ln_down       = !(min0 < min1);
      ln_err        = int'(ln_span_major) / 2;
      ln_color      = d[PEN_LSB +: COLOR_W];
      ln_active     = 1'b1;
      lines_started++;
    end else if (ln_active) begin
      at_end   = (ln_major == ln_major_end);
      emits    = 1'b1;
      px.x     = ln_steep ? ln_minor : ln_major;
      px.y     = ln_steep ? ln_major : ln_minor;
      px.color = ln_color;
      px.last  = at_end;
      if (at_end) begin
        ln_active = 1'b0;
      end else begin
        ln_major = ln_major + 1'b1;
        ln_err   = ln_err - int'(ln_span_minor);
        if (ln_err < 0) begin
          ln_minor = ln_down ? ln_minor - 1'b1 : ln_minor + 1'b1;
          ln_err   = ln_err + int'(ln_span_major);
        end
      end
    end
  endfunction

  // Offer one beat after a random idle gap, hold it until accepted
  task automatic offer_beat(input kind_t k, input logic [IN_DATA_W-1:0] d,
                            input row_check_t chk, input pixel_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    beat_note_q.push_back('{chk, want});
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= k;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= LONG_HOLD;
      hold_done     <= 1'b1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check pixels leaving the block, then predict from beats entering it
  always @(posedge clk) begin : scoreboard
    pixel_t     got, want, px;
    beat_note_t note;
    logic       emits;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.x     = m_axis_tdata[PIX_W-1:0];
        got.y     = m_axis_tdata[2*PIX_W-1:PIX_W];
        got.color = m_axis_tdata[2*PIX_W +: COLOR_W];
        got.last  = m_axis_tlast;
        if (pixel_expect_q.size() == 0) begin
          $error("pixel (%0d,%0d) with no pixel expected", got.x, got.y);
          fail_count++;
        end else begin
          want = pixel_expect_q.pop_front();
          if (got.x !== want.x) begin
            $error("pixel_x: expected %0d, actual %0d", want.x, got.x);
            fail_count++;
          end
          if (got.y !== want.y) begin
            $error("pixel_y: expected %0d, actual %0d", want.y, got.y);
            fail_count++;
          end
          if (got.color !== want.color) begin
            $error("pixel_color: expected %h, actual %h", want.color, got.color);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last_pixel: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
          end
        end
        pixels_checked++;
        if (got.last) lines_finished++;
      end
      if (s_axis_tvalid && !s_axis_tready) input_stall_cycles++;
      if (s_axis_tvalid && s_axis_tready) begin
        note.chk  = CHK_MODEL;
        note.want = '0;
        if (beat_note_q.size() != 0) note = beat_note_q.pop_front();
        bresenham_advance(kind_t'(s_axis_tuser), s_axis_tdata, emits, px);
        beats_in++;
        case (note.chk)
          CHK_MODEL: if (emits) pixel_expect_q.push_back(px);
          CHK_PIXEL: pixel_expect_q.push_back(note.want);
          default: ;
        endcase
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("line_rasterizer_unit regression: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int rand_beats;
    int r, reach, len, nsteps;
    logic [PIX_W-1:0] sx, sy, ex, ey;
    rand_beats = 0;
    ln_major = '0; ln_minor = '0; ln_major_end = '0;
    ln_span_major = '0; ln_span_minor = '0; ln_err = 0;
    ln_steep = 1'b0; ln_down = 1'b0; ln_active = 1'b0; ln_color = '0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (line_plan[i]) begin
      offer_beat(line_plan[i].kind,
                 pack_line(line_plan[i].sx, line_plan[i].sy, line_plan[i].ex,
                           line_plan[i].ey, line_plan[i].pen),
                 line_plan[i].chk, line_plan[i].want);
    end

    // random line sequences, idling swapped by phase
    while (rand_beats < RANDOM_BEATS) begin
      if (rand_beats >= 2 * RANDOM_BEATS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
      end else if (rand_beats >= RANDOM_BEATS / 3) begin
        send_idle_pct = 77;
        recv_idle_pct = 33;
      end

      r = $urandom_range(99);
      if (r < 8) begin
        // noise: any kind, any payload
        offer_beat(kind_t'($urandom_range(1)), {$urandom, $urandom}, CHK_MODEL, '0);
      end else begin
        r = $urandom_range(99);
        if (r < 5) begin
          sx = rail_coord(); sy = rail_coord();
          ex = rail_coord(); ey = rail_coord();
        end else begin
          reach = (r < 85) ? 12 : (r < 96) ? 200 : 4095;
          sx = PIX_W'($urandom_range(4095));
          sy = PIX_W'($urandom_range(4095));
          ex = near_coord(int'(sx), reach);
          ey = near_coord(int'(sy), reach);
        end
        len = int'((abs_diff(sx, ex) > abs_diff(sy, ey)) ? abs_diff(sx, ex)
                                                          : abs_diff(sy, ey)) + 1;
        // mostly run the line out, sometimes drop it early
        if (len <= 300 && $urandom_range(99) < 80) nsteps = len + $urandom_range(2);
        else nsteps = $urandom_range((len < 40) ? len - 1 : 40);

        offer_beat(KIND_START,
                   pack_line(sx, sy, ex, ey, COLOR_W'($urandom_range(16'hFFFF))),
                   CHK_MODEL, '0);
        rand_beats++;
        repeat (nsteps) begin
          offer_beat(KIND_STEP, {$urandom, $urandom}, CHK_MODEL, '0);
          rand_beats++;
        end
      end
    end
    s_axis_tvalid <= 1'b0;

    // drain, then give stray pixels a chance to show up
    while (pixel_expect_q.size() != 0 || hold_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d input beats over %0d lines, %0d lines drawn to their last pixel",
             beats_in, lines_started, lines_finished);
    $display("checked %0d pixels, input held off for %0d cycles by backpressure",
             pixels_checked, input_stall_cycles);
    if (fail_count == 0) begin
      $display("line_rasterizer_unit regression: pass");
    end else begin
      $display("line_rasterizer_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
